FILE: rtl/rbdo_pkg.sv
// Shared constants, command and status codes, and the operation struct for the
// ring buffer deque. No dependencies.
package rbdo_pkg;

    localparam int RBDO_DEPTH_DEFAULT = 64;
    localparam int RBDO_DATA_W_DEFAULT = 32;

    localparam int RBDO_CMD_W = 3;
    localparam int RBDO_POS_W = 6;
    localparam int RBDO_SLOT_W = 7;
    localparam int RBDO_CAP_W = 7;
    localparam int RBDO_STATUS_W = 2;
    localparam int RBDO_RD_W = 32;
    localparam int RBDO_APB_DW = 32;
    localparam int RBDO_APB_AW = 3;

    localparam logic [RBDO_CMD_W-1:0] CMD_PUSH_BACK = 3'd0;
    localparam logic [RBDO_CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [RBDO_CMD_W-1:0] CMD_POP_BACK = 3'd2;
    localparam logic [RBDO_CMD_W-1:0] CMD_POP_FRONT = 3'd3;
    localparam logic [RBDO_CMD_W-1:0] CMD_READ = 3'd4;
    localparam logic [RBDO_CMD_W-1:0] CMD_WRITE = 3'd5;

    localparam logic [RBDO_STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [RBDO_STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [RBDO_STATUS_W-1:0] ST_RANGE = 2'd2;

    // word index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic                     we;
        logic [RBDO_SLOT_W-1:0]   waddr;
        logic                     re;
        logic [RBDO_SLOT_W-1:0]   raddr;
        logic [RBDO_STATUS_W-1:0] status;
        logic [RBDO_CAP_W-1:0]    count;
        logic                     empty;
        logic                     full;
    } rbdo_op_t;

endpackage

FILE: rtl/rbdo_cmd_if.sv
// Command channel: valid/ready handshake carrying one deque command.
// Depends on rbdo_pkg.
interface rbdo_cmd_if
    import rbdo_pkg::*;
#(
    parameter int DATA_WIDTH = RBDO_DATA_W_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [RBDO_CMD_W-1:0] cmd;
    logic [RBDO_POS_W-1:0] position;
    logic [DATA_WIDTH-1:0] data_in;

    modport source (output valid, cmd, position, data_in, input ready);
    modport sink (input valid, cmd, position, data_in, output ready);
endinterface

FILE: rtl/rbdo_res_if.sv
// Result channel: valid/ready handshake carrying one command result.
// Depends on rbdo_pkg.
interface rbdo_res_if
    import rbdo_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [RBDO_RD_W-1:0]     read_data;
    logic [RBDO_STATUS_W-1:0] status;
    logic [RBDO_CAP_W-1:0]    occupancy;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, read_data, status, occupancy, is_empty, is_full,
                    input ready);
    modport sink (input valid, read_data, status, occupancy, is_empty, is_full,
                  output ready);
endinterface

FILE: rtl/rbdo_regs.sv
// APB-style configuration register file: capacity in use, with clamping.
// A write pulses clear to empty the buffer. Depends on rbdo_pkg.
module rbdo_regs
    import rbdo_pkg::*;
#(
    parameter int DEPTH = RBDO_DEPTH_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [RBDO_APB_AW-1:0] paddr,
    input  logic [RBDO_APB_DW-1:0] pwdata,
    output logic [RBDO_APB_DW-1:0] prdata,
    output logic                   pready,
    output logic [RBDO_CAP_W-1:0]  cap,
    output logic                   clear
);
    localparam logic [RBDO_CAP_W-1:0] CAP_RESET =
        (DEPTH < 64) ? RBDO_CAP_W'(DEPTH) : RBDO_CAP_W'(64);

    logic [RBDO_CAP_W-1:0] cap_reg;
    logic [RBDO_CAP_W-1:0] cap_next;
    logic                  wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign clear = wr_cap;
    assign cap = cap_reg;

    always_comb
    begin
        cap_next = pwdata[RBDO_CAP_W-1:0];
        if (cap_next == '0)
        begin
            cap_next = RBDO_CAP_W'(1);
        end
        if (32'(cap_next) > 32'(DEPTH))
        begin
            cap_next = RBDO_CAP_W'(DEPTH);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata[RBDO_CAP_W-1:0] = cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_cap)
        begin
            cap_reg <= cap_next;
        end
    end
endmodule

FILE: rtl/rbdo_ctrl.sv
// Pointer and count control: decodes one command against the ring state and
// updates first/last slot and element count. Depends on rbdo_pkg.
module rbdo_ctrl
    import rbdo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  clear,
    input  logic [RBDO_CMD_W-1:0] cmd,
    input  logic [RBDO_POS_W-1:0] position,
    input  logic [RBDO_CAP_W-1:0] cap,
    output rbdo_op_t              op
);
    logic [RBDO_SLOT_W-1:0] first_reg, first_next;
    logic [RBDO_SLOT_W-1:0] last_reg, last_next;
    logic [RBDO_CAP_W-1:0]  count_reg, count_next;
    logic [RBDO_SLOT_W:0]   logical_sum;
    logic [RBDO_SLOT_W-1:0] logical_slot;
    logic                   is_full_now;
    logic                   in_range;

    function automatic logic [RBDO_SLOT_W-1:0] ring_next(
        input logic [RBDO_SLOT_W-1:0] i,
        input logic [RBDO_CAP_W-1:0]  c
    );
        logic [RBDO_SLOT_W:0] s;
        s = {1'b0, i} + 1'b1;
        return (s >= {1'b0, c}) ? '0 : s[RBDO_SLOT_W-1:0];
    endfunction

    function automatic logic [RBDO_SLOT_W-1:0] ring_prev(
        input logic [RBDO_SLOT_W-1:0] i,
        input logic [RBDO_CAP_W-1:0]  c
    );
        return (i == '0) ? RBDO_SLOT_W'(c - 1'b1) : i - 1'b1;
    endfunction

    assign is_full_now = (count_reg >= cap);
    assign in_range = ({1'b0, position} < count_reg);

    always_comb
    begin
        logical_sum = {1'b0, first_reg} + {2'b0, position};
        if (logical_sum >= {1'b0, cap})
        begin
            logical_sum = logical_sum - {1'b0, cap};
        end
        logical_slot = logical_sum[RBDO_SLOT_W-1:0];
    end

    always_comb
    begin
        first_next = first_reg;
        last_next = last_reg;
        count_next = count_reg;
        op.we = 1'b0;
        op.waddr = first_reg;
        op.re = 1'b0;
        op.raddr = logical_slot;
        op.status = ST_OK;
        case (cmd)
            CMD_PUSH_BACK:
            begin
                op.we = 1'b1;
                if (count_reg == '0)
                begin
                    last_next = first_reg;
                    count_next = RBDO_CAP_W'(1);
                    op.waddr = first_reg;
                end
                else
                begin
                    last_next = ring_next(last_reg, cap);
                    if (is_full_now)
                    begin
                        first_next = ring_next(first_reg, cap);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    op.waddr = last_next;
                end
            end
            CMD_PUSH_FRONT:
            begin
                op.we = 1'b1;
                if (count_reg == '0)
                begin
                    last_next = first_reg;
                    count_next = RBDO_CAP_W'(1);
                    op.waddr = first_reg;
                end
                else
                begin
                    first_next = ring_prev(first_reg, cap);
                    if (is_full_now)
                    begin
                        last_next = ring_prev(last_reg, cap);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    op.waddr = first_next;
                end
            end
            CMD_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    op.status = ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    last_next = (count_next == '0) ? first_reg : ring_prev(last_reg, cap);
                end
            end
            CMD_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    op.status = ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    first_next = (count_next == '0) ? last_reg : ring_next(first_reg, cap);
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    op.re = 1'b1;
                end
                else
                begin
                    op.status = ST_RANGE;
                end
            end
            CMD_WRITE:
            begin
                op.waddr = logical_slot;
                if (in_range)
                begin
                    op.we = 1'b1;
                end
                else
                begin
                    op.status = ST_RANGE;
                end
            end
            default:
            begin
            end
        endcase
        op.count = count_next;
        op.empty = (count_next == '0);
        op.full = (count_next == cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            last_reg <= '0;
            count_reg <= '0;
        end
        else if (clear)
        begin
            first_reg <= '0;
            last_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            first_reg <= first_next;
            last_reg <= last_next;
            count_reg <= count_next;
        end
    end
endmodule

FILE: rtl/rbdo_mem.sv
// Slot storage: one write and one registered read per transfer. A transfer
// that does not read loads zero into the read register. Depends on rbdo_pkg.
module rbdo_mem
    import rbdo_pkg::*;
#(
    parameter int DEPTH = RBDO_DEPTH_DEFAULT,
    parameter int DATA_WIDTH = RBDO_DATA_W_DEFAULT
)(
    input  logic                  clk,
    input  logic                  accept,
    input  rbdo_op_t              op,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;

    assign waddr = AW'(op.waddr);
    assign raddr = AW'(op.raddr);
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= op.re ? mem[raddr] : '0;
        end
    end
endmodule

FILE: rtl/ring_buffer_deque_overwrite.sv
// Double-ended ring buffer with overwrite on full: top level with channel
// handshake and result register. Depends on rbdo_pkg, rbdo_cmd_if, rbdo_res_if,
// rbdo_regs, rbdo_ctrl and rbdo_mem.
//
// Takes one command per clock and returns its result in the cycle after the
// transfer; pointer update, slot write and slot read happen in the same cycle
// through the slot memory's one write port and one registered read port. The
// command channel stalls only while a result is held and not taken. Writing
// capacity_in_use (address 0) clamps it to 1..DEPTH and empties the buffer at
// once; slot contents are never cleared and unwritten slots are unreachable.
// read_data carries the low 32 bits of a stored element, zero unless the
// command is an in-range read.
module ring_buffer_deque_overwrite
    import rbdo_pkg::*;
#(
    parameter int DEPTH = RBDO_DEPTH_DEFAULT,
    parameter int DATA_WIDTH = RBDO_DATA_W_DEFAULT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [RBDO_APB_AW-1:0] paddr,
    input  logic [RBDO_APB_DW-1:0] pwdata,
    output logic [RBDO_APB_DW-1:0] prdata,
    output logic                   pready,
    rbdo_cmd_if.sink               cmd_ch,
    rbdo_res_if.source             res_ch
);
    localparam int RW = (DATA_WIDTH < RBDO_RD_W) ? DATA_WIDTH : RBDO_RD_W;

    logic [RBDO_CAP_W-1:0]    cap;
    logic                     clear;
    logic                     accept;
    rbdo_op_t                 op;
    logic [DATA_WIDTH-1:0]    rdata;
    logic                     valid_reg;
    logic [RBDO_STATUS_W-1:0] status_reg;
    logic [RBDO_CAP_W-1:0]    occ_reg;
    logic                     empty_reg;
    logic                     full_reg;

    rbdo_regs #(
        .DEPTH(DEPTH)
    ) u_regs (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cap(cap),
        .clear(clear)
    );

    rbdo_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .clear(clear),
        .cmd(cmd_ch.cmd),
        .position(cmd_ch.position),
        .cap(cap),
        .op(op)
    );

    rbdo_mem #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mem (
        .clk(clk),
        .accept(accept),
        .op(op),
        .wdata(cmd_ch.data_in),
        .rdata(rdata)
    );

    assign cmd_ch.ready = !valid_reg || res_ch.ready;
    assign accept = cmd_ch.valid && cmd_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_ch.ready)
        begin
            valid_reg <= cmd_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= op.status;
            occ_reg <= op.count;
            empty_reg <= op.empty;
            full_reg <= op.full;
        end
    end

    always_comb
    begin
        res_ch.read_data = '0;
        res_ch.read_data[RW-1:0] = rdata[RW-1:0];
    end

    assign res_ch.valid = valid_reg;
    assign res_ch.status = status_reg;
    assign res_ch.occupancy = occ_reg;
    assign res_ch.is_empty = empty_reg;
    assign res_ch.is_full = full_reg;

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_ch.valid)
        else $error("transfer did not produce a result");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> (res_ch.occupancy <= cap))
        else $error("occupancy above capacity");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && (res_ch.status != ST_OK)) |-> (res_ch.read_data == '0))
        else $error("read data on a failed command");
`endif
endmodule

FILE: test/ring_buffer_deque_overwrite_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_buffer_deque_overwrite: directed and random deque commands
// with capacity changes over APB. Depends on rbdo_pkg, rbdo_cmd_if, rbdo_res_if and the RTL.
module ring_buffer_deque_overwrite_test;
    import rbdo_pkg::*;

    localparam logic [RBDO_CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [RBDO_CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam logic [RBDO_APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    localparam int SLOTS = RBDO_DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 155;

    typedef struct packed {
        logic [RBDO_RD_W-1:0]     read_data;
        logic [RBDO_STATUS_W-1:0] status;
        logic [RBDO_CAP_W-1:0]    occupancy;
        logic                     is_empty;
        logic                     is_full;
    } deque_result_t;

    class deque_shadow;
        logic [RBDO_RD_W-1:0] slots [SLOTS];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        int unsigned cap;
        deque_result_t pending_results[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned overwrites;
        int unsigned empty_pops;
        int unsigned range_misses;

        function new();
            cap = SLOTS;
            head = 0;
            tail = 0;
            fill = 0;
        endfunction

        function int unsigned after_slot(int unsigned i);
            return (i + 1 >= cap) ? 0 : i + 1;
        endfunction

        function int unsigned before_slot(int unsigned i);
            return (i == 0) ? cap - 1 : i - 1;
        endfunction

        function void apply_capacity(logic [RBDO_APB_DW-1:0] value);
            int unsigned v;
            v = 32'(value[RBDO_CAP_W-1:0]);
            if (v < 1)
                v = 1;
            if (v > SLOTS)
                v = SLOTS;
            cap = v;
            head = 0;
            tail = 0;
            fill = 0;
        endfunction

        function void note_command(logic [RBDO_CMD_W-1:0] op, logic [RBDO_POS_W-1:0] pos,
                                   logic [RBDO_RD_W-1:0] data);
            deque_result_t r;
            int unsigned slot;
            r = '0;
            r.status = ST_OK;
            slot = head + pos;
            if (slot >= cap)
                slot -= cap;
            case (op)
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (fill == 0)
                    begin
                        tail = head;
                        fill = 1;
                    end
                    else if (op == CMD_PUSH_BACK)
                    begin
                        tail = after_slot(tail);
                        if (fill >= cap)
                        begin
                            head = after_slot(head);
                            overwrites++;
                        end
                        else
                            fill++;
                    end
                    else
                    begin
                        head = before_slot(head);
                        if (fill >= cap)
                        begin
                            tail = before_slot(tail);
                            overwrites++;
                        end
                        else
                            fill++;
                    end
                    slots[(op == CMD_PUSH_BACK) ? tail : head] = data;
                end
                CMD_POP_BACK, CMD_POP_FRONT:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_POP_EMPTY;
                        empty_pops++;
                    end
                    else
                    begin
                        fill--;
                        if (op == CMD_POP_BACK)
                            tail = (fill == 0) ? head : before_slot(tail);
                        else
                            head = (fill == 0) ? tail : after_slot(head);
                    end
                end
                CMD_READ, CMD_WRITE:
                begin
                    if (pos >= fill)
                    begin
                        r.status = ST_RANGE;
                        range_misses++;
                    end
                    else if (op == CMD_READ)
                        r.read_data = slots[slot];
                    else
                        slots[slot] = data;
                end
                default:
                begin
                end
            endcase
            r.occupancy = RBDO_CAP_W'(fill);
            r.is_empty = (fill == 0);
            r.is_full = (fill == cap);
            pending_results = {pending_results, r};
        endfunction

        function void check_result(deque_result_t got);
            deque_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result transfer with nothing outstanding", $realtime);
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch data %h/%h status %0d/%0d occ %0d/%0d empty %b/%b full %b/%b (exp/act)",
                             $realtime, want.read_data, got.read_data, want.status, got.status,
                             want.occupancy, got.occupancy, want.is_empty, got.is_empty,
                             want.is_full, got.is_full);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [RBDO_APB_AW-1:0] paddr;
    logic [RBDO_APB_DW-1:0] pwdata;
    logic [RBDO_APB_DW-1:0] prdata;
    logic pready;

    rbdo_cmd_if cmd_ch();
    rbdo_res_if res_ch();

    deque_shadow shadow;
    bit idle_on;
    bit hold_request;
    int unsigned holds_done;
    int unsigned items_sent;
    int unsigned cap_writes;

    ring_buffer_deque_overwrite dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cmd_ch(cmd_ch),
        .res_ch(res_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_command(logic [RBDO_CMD_W-1:0] op, logic [RBDO_POS_W-1:0] pos,
                                logic [RBDO_RD_W-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= op;
        cmd_ch.position <= pos;
        cmd_ch.data_in <= data;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        shadow.note_command(op, pos, data);
        items_sent++;
    endtask

    task automatic wait_results_done();
        cmd_ch.valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [RBDO_APB_DW-1:0] value);
        wait_results_done();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow.apply_capacity(value);
        cap_writes++;
    endtask

    task automatic random_command(int push_pct, int pop_pct);
        logic [RBDO_CMD_W-1:0] op;
        logic [RBDO_POS_W-1:0] pos;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (roll < 97)
            op = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
        else
            op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        if (shadow.fill > 0 && $urandom_range(0, 3) != 0)
            pos = RBDO_POS_W'($urandom_range(0, shadow.fill - 1));
        else
            pos = RBDO_POS_W'($urandom_range(0, SLOTS - 1));
        send_command(op, pos, $urandom);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        deque_result_t got;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else
            begin
                gap = idle_on ? $urandom_range(0, 6) : 0;
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.read_data = res_ch.read_data;
            got.status = res_ch.status;
            got.occupancy = res_ch.occupancy;
            got.is_empty = res_ch.is_empty;
            got.is_full = res_ch.is_full;
            shadow.check_result(got);
        end
    end

    initial
    begin
        logic [RBDO_APB_DW-1:0] caps [PHASES];
        int push_pct;
        int pop_pct;
        int settle;
        shadow = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_PUSH_BACK;
        cmd_ch.position = '0;
        cmd_ch.data_in = '0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty buffer at reset capacity, then basic traffic
        send_command(CMD_POP_BACK, 6'd0, 32'h0);
        send_command(CMD_POP_FRONT, 6'd0, 32'h0);
        send_command(CMD_READ, 6'd0, 32'h0);
        send_command(CMD_WRITE, 6'd63, 32'h1234_5678);
        send_command(CMD_SPARE_6, 6'd63, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_7, 6'd0, 32'h0);
        send_command(CMD_PUSH_BACK, 6'd0, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_FRONT, 6'd63, 32'h0000_0000);
        send_command(CMD_READ, 6'd0, 32'h0);
        send_command(CMD_READ, 6'd1, 32'h0);
        send_command(CMD_READ, 6'd2, 32'h0);
        send_command(CMD_WRITE, 6'd1, 32'hA5A5_A5A5);
        send_command(CMD_READ, 6'd1, 32'h0);
        send_command(CMD_POP_BACK, 6'd0, 32'h0);
        send_command(CMD_POP_FRONT, 6'd0, 32'h0);
        send_command(CMD_PUSH_FRONT, 6'd0, 32'h5A5A_5A5A);
        send_command(CMD_READ, 6'd0, 32'h0);

        // small capacity: overwrite from both ends
        write_capacity(32'd2);
        send_command(CMD_PUSH_BACK, 6'd0, 32'h0000_0001);
        send_command(CMD_PUSH_BACK, 6'd0, 32'h0000_0002);
        send_command(CMD_PUSH_BACK, 6'd0, 32'h0000_0003);
        send_command(CMD_PUSH_FRONT, 6'd0, 32'h8000_0000);
        send_command(CMD_READ, 6'd0, 32'h0);
        send_command(CMD_READ, 6'd1, 32'h0);
        send_command(CMD_READ, 6'd63, 32'h0);

        caps[0] = 32'd64;
        caps[1] = 32'd1;
        caps[2] = 32'd0;
        caps[3] = 32'd3;
        caps[4] = 32'd127;
        caps[5] = 32'hFFFF_FF85;
        caps[6] = 32'd100;
        caps[7] = 32'd64;
        caps[8] = 32'd17;
        caps[9] = 32'd2;
        caps[10] = 32'd33;
        caps[11] = $urandom_range(0, 127);

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(caps[p]);
            case (p % 3)
                0: begin push_pct = 65; pop_pct = 10; end
                1: begin push_pct = 40; pop_pct = 35; end
                default: begin push_pct = 30; pop_pct = 45; end
            endcase
            idle_on = (p % 4 != 3);
            if (p == 3)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 6 && i == PHASE_ITEMS / 2)
                    wait_results_done();
                random_command(push_pct, pop_pct);
            end
        end

        cmd_ch.valid <= 1'b0;
        settle = 0;
        while (shadow.pending_results.size() != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (8) @(posedge clk);
        if (shadow.pending_results.size() != 0)
        begin
            $display("%0d results never arrived", shadow.pending_results.size());
            shadow.errors += shadow.pending_results.size();
        end

        $display("%0d commands, %0d results checked across %0d capacity writes, %0d long stalls",
                 items_sent, shadow.checked, cap_writes, holds_done);
        $display("%0d overwrites on full, %0d pops on empty, %0d positions out of range",
                 shadow.overwrites, shadow.empty_pops, shadow.range_misses);
        if (shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
